### rtl/core/fbsl_pkg.sv
// ----------------------------------------------------------------------------
// FAT boot sector layout package
// Shared types and constants for the boot sector check and layout unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fbsl_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SECTORS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT12_LIMIT    = 1'b1;
  localparam int unsigned CFG_DATA_W = 64;

  // Reset value of the FAT12 cluster limit.
  localparam logic [27:0] FAT12_LIMIT_RESET = 28'd4084;

  // Accepted logical sector sizes.
  localparam logic [15:0] SECTOR_512  = 16'd512;
  localparam logic [15:0] SECTOR_1024 = 16'd1024;
  localparam logic [15:0] SECTOR_2048 = 16'd2048;
  localparam logic [15:0] SECTOR_4096 = 16'd4096;

  // FAT entry widths.
  localparam logic [5:0] FAT_W12 = 6'd12;
  localparam logic [5:0] FAT_W16 = 6'd16;
  localparam logic [5:0] FAT_W32 = 6'd32;

  // Volume size limit in device sectors.
  localparam logic [35:0] VOLUME_SECTOR_MAX = 36'h1_0000_0000;

  // One boot sector parameter block request.
  typedef struct packed {
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  fat_copies;
    logic [15:0] total_small;
    logic [31:0] total_large;
    logic [15:0] fat_size_small;
    logic [31:0] fat_size_large;
    logic [15:0] root_entry_count;
    logic [31:0] root_start_cluster;
  } bpb_t;

  // One layout result.
  typedef struct packed {
    logic        valid_res;
    logic [5:0]  fat_width;
    logic [31:0] volume_sectors;
    logic [31:0] sectors_per_fat;
    logic [31:0] data_start;
    logic [31:0] clusters;
    logic [31:0] root_cluster_out;
    logic [31:0] root_sector;
    logic [15:0] root_entries_out;
  } layout_t;

endpackage

`default_nettype wire

### rtl/core/fat_boot_sector_layout_unit.sv
// ----------------------------------------------------------------------------
// FAT boot sector layout unit
// Checks a FAT boot sector parameter block and reports the volume layout.
// ----------------------------------------------------------------------------
// The unit takes one parameter block request per clock cycle unless stalled and
// returns one result per request, in order: a request accepted at a clock edge
// is captured in an input register, checked and laid out by combinational
// logic, and loaded into the result register when that register is free or
// taken; the result is held there until taken. A waiting result stalls the
// input only while the result register stays full. The clock rate is bounded
// by the layout logic, whose longest path is the 8 by 32 bit FAT size product
// followed by the data start sum, its compare with the volume size and the
// cluster count compare.
// The user must write device size and the FAT12 cluster limit through the
// register port while no request is in flight; the unit does not enforce this.
`default_nettype none

module fat_boot_sector_layout_unit #(
  parameter int unsigned DEVICE_SECTOR_BYTES = 512
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Register port.
  input  wire                                 cfg_we_i,
  input  wire  [fbsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [fbsl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Parameter block request channel.
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [15:0]                         sector_bytes_i,
  input  wire  [7:0]                          cluster_sectors_i,
  input  wire  [15:0]                         reserved_count_i,
  input  wire  [7:0]                          fat_copies_i,
  input  wire  [15:0]                         total_small_i,
  input  wire  [31:0]                         total_large_i,
  input  wire  [15:0]                         fat_size_small_i,
  input  wire  [31:0]                         fat_size_large_i,
  input  wire  [15:0]                         root_entry_count_i,
  input  wire  [31:0]                         root_start_cluster_i,
  // Layout result channel.
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic                                valid_res_o,
  output logic [5:0]                          fat_width_o,
  output logic [31:0]                         volume_sectors_o,
  output logic [31:0]                         sectors_per_fat_o,
  output logic [31:0]                         data_start_o,
  output logic [31:0]                         clusters_o,
  output logic [31:0]                         root_cluster_out_o,
  output logic [31:0]                         root_sector_o,
  output logic [15:0]                         root_entries_out_o
);
  import fbsl_pkg::*;

  logic [63:0] dev_sectors_q;
  logic [27:0] fat12_limit_q;
  bpb_t        in_bpb;
  bpb_t        s1_bpb;
  logic        s1_valid;
  logic        s1_ready;
  layout_t     s1_res;
  logic        out_valid_q, out_valid_d;
  layout_t     out_res_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sectors_q <= 64'd0;
      fat12_limit_q <= FAT12_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_SECTORS: dev_sectors_q <= cfg_data_i;
        CFG_FAT12_LIMIT:    fat12_limit_q <= cfg_data_i[27:0];
        default: begin
        end
      endcase
    end
  end

  // Gather the request fields.
  always_comb begin
    in_bpb.sector_bytes        = sector_bytes_i;
    in_bpb.cluster_sectors     = cluster_sectors_i;
    in_bpb.reserved_count      = reserved_count_i;
    in_bpb.fat_copies          = fat_copies_i;
    in_bpb.total_small         = total_small_i;
    in_bpb.total_large         = total_large_i;
    in_bpb.fat_size_small      = fat_size_small_i;
    in_bpb.fat_size_large      = fat_size_large_i;
    in_bpb.root_entry_count    = root_entry_count_i;
    in_bpb.root_start_cluster  = root_start_cluster_i;
  end

  fbsl_bpb_reg u_bpb_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_bpb_i   (in_bpb),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_bpb_o   (s1_bpb)
  );

  fbsl_layout #(
    .DEVICE_SECTOR_BYTES (DEVICE_SECTOR_BYTES)
  ) u_layout (
    .bpb_i            (s1_bpb),
    .device_sectors_i (dev_sectors_q),
    .fat12_limit_i    (fat12_limit_q),
    .res_o            (s1_res)
  );

  // Result register: refills in the cycle its content is taken.
  assign s1_ready    = !out_valid_q || out_ready_i;
  assign out_valid_d = s1_ready ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid && s1_ready) begin
      out_res_q <= s1_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign valid_res_o        = out_res_q.valid_res;
  assign fat_width_o        = out_res_q.fat_width;
  assign volume_sectors_o   = out_res_q.volume_sectors;
  assign sectors_per_fat_o  = out_res_q.sectors_per_fat;
  assign data_start_o       = out_res_q.data_start;
  assign clusters_o         = out_res_q.clusters;
  assign root_cluster_out_o = out_res_q.root_cluster_out;
  assign root_sector_o      = out_res_q.root_sector;
  assign root_entries_out_o = out_res_q.root_entries_out;

endmodule

`default_nettype wire

### rtl/core/fbsl_bpb_reg.sv
// ----------------------------------------------------------------------------
// Parameter block input register
// Captures one request per cycle and holds it while the next stage stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsl_bpb_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire fbsl_pkg::bpb_t in_bpb_i,
  output logic                s1_valid_o,
  input  wire                 s1_ready_i,
  output fbsl_pkg::bpb_t      s1_bpb_o
);
  import fbsl_pkg::*;

  logic valid_q, valid_d;
  bpb_t bpb_q;

  // The register frees up whenever its content moves on in the same cycle.
  assign in_ready_o = !valid_q || s1_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads only on an accepted request.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      bpb_q <= in_bpb_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_bpb_o   = bpb_q;

endmodule

`default_nettype wire

### rtl/core/fbsl_layout.sv
// ----------------------------------------------------------------------------
// Parameter block check and layout logic
// Combinational checks and layout arithmetic for one parameter block.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsl_layout #(
  parameter int unsigned DEVICE_SECTOR_BYTES = 512
) (
  input  wire fbsl_pkg::bpb_t bpb_i,
  input  wire  [63:0]         device_sectors_i,
  input  wire  [27:0]         fat12_limit_i,
  output fbsl_pkg::layout_t   res_o
);
  import fbsl_pkg::*;

  // Logical sectors to device sectors, one factor per accepted sector size.
  localparam int unsigned RATIO_512  = 512 / DEVICE_SECTOR_BYTES;
  localparam int unsigned RATIO_1024 = 1024 / DEVICE_SECTOR_BYTES;
  localparam int unsigned RATIO_2048 = 2048 / DEVICE_SECTOR_BYTES;
  localparam int unsigned RATIO_4096 = 4096 / DEVICE_SECTOR_BYTES;

  logic        sec_ok, clus_ok, count_ok, vol_ok, fat_ok, span_ok, ok;
  logic [3:0]  bshift;
  logic [3:0]  ratio;
  logic [2:0]  cshift;
  logic [31:0] total;
  logic [35:0] psec;
  logic        is_fat32;
  logic [31:0] fatsz;
  logic [21:0] rds_sum;
  logic [21:0] rds;
  logic [39:0] fats;
  logic [40:0] meta_end;
  logic [40:0] dstart;
  logic [31:0] ncl;
  logic [5:0]  width;

  // Sector size decode: shift and device sector factor.
  always_comb begin
    sec_ok = 1'b1;
    bshift = 4'd9;
    ratio  = 4'(RATIO_512);
    case (bpb_i.sector_bytes)
      SECTOR_512: begin
        bshift = 4'd9;
        ratio  = 4'(RATIO_512);
      end
      SECTOR_1024: begin
        bshift = 4'd10;
        ratio  = 4'(RATIO_1024);
      end
      SECTOR_2048: begin
        bshift = 4'd11;
        ratio  = 4'(RATIO_2048);
      end
      SECTOR_4096: begin
        bshift = 4'd12;
        ratio  = 4'(RATIO_4096);
      end
      default: begin
        sec_ok = 1'b0;
      end
    endcase
  end

  // Cluster size must be a single set bit; its position is the shift.
  always_comb begin
    cshift = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (bpb_i.cluster_sectors[i]) begin
        cshift = 3'(i);
      end
    end
    clus_ok = (bpb_i.cluster_sectors != 8'd0) &&
              ((bpb_i.cluster_sectors & (bpb_i.cluster_sectors - 8'd1)) == 8'd0);
  end

  assign count_ok = (bpb_i.reserved_count != 16'd0) && (bpb_i.fat_copies != 8'd0);

  // Volume size, checked in device sectors.
  assign total  = (bpb_i.total_small != 16'd0) ? {16'd0, bpb_i.total_small}
                                               : bpb_i.total_large;
  assign psec   = 36'(total) * 36'(ratio);
  assign vol_ok = (psec != 36'd0) && (psec <= VOLUME_SECTOR_MAX) &&
                  ({28'd0, psec} <= device_sectors_i);

  // FAT size: the small field wins when set.
  assign is_fat32 = (bpb_i.fat_size_small == 16'd0);
  assign fatsz    = is_fat32 ? bpb_i.fat_size_large : {16'd0, bpb_i.fat_size_small};
  assign fat_ok   = !is_fat32 || (bpb_i.fat_size_large != 32'd0);

  // Root directory sectors, rounded up to whole sectors.
  assign rds_sum = {1'b0, bpb_i.root_entry_count, 5'd0} +
                   {6'd0, bpb_i.sector_bytes} - 22'd1;
  assign rds     = rds_sum >> bshift;

  // Data area start and cluster count.
  assign fats     = 40'(bpb_i.fat_copies) * 40'(fatsz);
  assign meta_end = 41'(bpb_i.reserved_count) + 41'(fats);
  assign dstart   = meta_end + 41'(rds);
  assign span_ok  = dstart < 41'(total);
  assign ncl      = (total - dstart[31:0]) >> cshift;

  assign width = is_fat32 ? FAT_W32
               : ((ncl <= {4'd0, fat12_limit_i}) ? FAT_W12 : FAT_W16);

  assign ok = sec_ok && clus_ok && count_ok && vol_ok && fat_ok && span_ok;

  // An invalid block reports all fields as zero.
  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.valid_res       = 1'b1;
      res_o.fat_width       = width;
      res_o.volume_sectors  = total;
      res_o.sectors_per_fat = fatsz;
      res_o.data_start      = dstart[31:0];
      res_o.clusters        = ncl;
      if (is_fat32) begin
        res_o.root_cluster_out = bpb_i.root_start_cluster;
      end else begin
        res_o.root_sector      = meta_end[31:0];
        res_o.root_entries_out = bpb_i.root_entry_count;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/fbsl_checker.sv
// ----------------------------------------------------------------------------
// FAT boot sector layout checker
// Port level checks on the layout result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbsl_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         out_valid_o,
  input  wire         out_ready_i,
  input  wire         valid_res_o,
  input  wire  [5:0]  fat_width_o,
  input  wire  [31:0] volume_sectors_o,
  input  wire  [31:0] sectors_per_fat_o,
  input  wire  [31:0] data_start_o,
  input  wire  [31:0] clusters_o,
  input  wire  [31:0] root_cluster_out_o,
  input  wire  [31:0] root_sector_o,
  input  wire  [15:0] root_entries_out_o
);
  import fbsl_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A rejected block reports nothing but zeros.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |->
      fat_width_o == 6'd0 && volume_sectors_o == 32'd0 &&
      sectors_per_fat_o == 32'd0 && data_start_o == 32'd0 && clusters_o == 32'd0 &&
      root_cluster_out_o == 32'd0 && root_sector_o == 32'd0 &&
      root_entries_out_o == 16'd0)
    else $error("invalid block with nonzero fields");

  // An accepted block has a legal FAT width.
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |->
      fat_width_o == FAT_W12 || fat_width_o == FAT_W16 || fat_width_o == FAT_W32)
    else $error("illegal FAT width");

  // The data area starts inside the volume, at or after the root directory start.
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |->
      data_start_o < volume_sectors_o && root_sector_o <= data_start_o)
    else $error("data area outside the volume");

  // FAT32 layouts carry no fixed root directory, FAT12/16 no root cluster.
  a_root_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |->
      (fat_width_o == FAT_W32) ? (root_sector_o == 32'd0 && root_entries_out_o == 16'd0)
                               : (root_cluster_out_o == 32'd0))
    else $error("root directory fields mixed between FAT kinds");

endmodule

bind fat_boot_sector_layout_unit fbsl_checker u_fbsl_checker (.*);

`default_nettype wire

### sim/fat_boot_sector_layout_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT boot sector layout unit regression
// Drives parameter block requests through the unit under random stalls on
// both channels, predicts each layout from the request and the current
// register values, and compares every result field in order.
// ----------------------------------------------------------------------------

module fat_boot_sector_layout_unit_test;

  import fbsl_pkg::*;

  localparam int unsigned DEV_SECTOR_BYTES = 512;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned CHUNK_ITEMS      = 70;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  bpb_t   req_q       = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  layout_t result;

  // Requests waiting to be driven and layouts waiting to be returned.
  bpb_t    pending_blocks[$];
  layout_t expected_layouts[$];
  layout_t expected_layout;

  // Shadow copies of the unit's registers.
  logic [63:0] dev_sectors_cfg = 64'd0;
  logic [27:0] fat12_limit_cfg = FAT12_LIMIT_RESET;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  fat_boot_sector_layout_unit #(
    .DEVICE_SECTOR_BYTES (DEV_SECTOR_BYTES)
  ) dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .sector_bytes_i        (req_q.sector_bytes),
    .cluster_sectors_i     (req_q.cluster_sectors),
    .reserved_count_i      (req_q.reserved_count),
    .fat_copies_i          (req_q.fat_copies),
    .total_small_i         (req_q.total_small),
    .total_large_i         (req_q.total_large),
    .fat_size_small_i      (req_q.fat_size_small),
    .fat_size_large_i      (req_q.fat_size_large),
    .root_entry_count_i    (req_q.root_entry_count),
    .root_start_cluster_i  (req_q.root_start_cluster),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .valid_res_o           (result.valid_res),
    .fat_width_o           (result.fat_width),
    .volume_sectors_o      (result.volume_sectors),
    .sectors_per_fat_o     (result.sectors_per_fat),
    .data_start_o          (result.data_start),
    .clusters_o            (result.clusters),
    .root_cluster_out_o    (result.root_cluster_out),
    .root_sector_o         (result.root_sector),
    .root_entries_out_o    (result.root_entries_out)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected layout of one parameter block under the current register values.
  // Any failed check gives an all-zero layout.
  function automatic layout_t predict_layout(input bpb_t b);
    layout_t     r;
    int unsigned sec_sh;
    int unsigned clu_sh;
    logic [63:0] total, dev_count, fat_len, root_secs, fat_area, first_data, ncl;
    logic [5:0]  width;
    r = '0;
    case (b.sector_bytes)
      SECTOR_512:  sec_sh = 9;
      SECTOR_1024: sec_sh = 10;
      SECTOR_2048: sec_sh = 11;
      SECTOR_4096: sec_sh = 12;
      default:     return r;
    endcase
    if (b.cluster_sectors == 8'd0 ||
        (b.cluster_sectors & (b.cluster_sectors - 8'd1)) != 8'd0) return r;
    clu_sh = 0;
    for (int s = 0; s < 8; s++) if (b.cluster_sectors[s]) clu_sh = s;
    if (b.reserved_count == 16'd0 || b.fat_copies == 8'd0) return r;

    // Volume size in device sectors must fit both the 2^32 limit and the device.
    total = (b.total_small != 16'd0) ? 64'(b.total_small) : 64'(b.total_large);
    dev_count = total * (64'(b.sector_bytes) / DEV_SECTOR_BYTES);
    if (dev_count == 64'd0 || dev_count > 64'(VOLUME_SECTOR_MAX) ||
        dev_count > dev_sectors_cfg) return r;

    // The small FAT size wins when set; otherwise the volume is FAT32.
    if (b.fat_size_small != 16'd0) begin
      width   = 6'd0;
      fat_len = 64'(b.fat_size_small);
    end else begin
      if (b.fat_size_large == 32'd0) return r;
      width   = FAT_W32;
      fat_len = 64'(b.fat_size_large);
    end

    root_secs  = (64'(b.root_entry_count) * 64'd32 + 64'(b.sector_bytes) - 64'd1)
                 >> sec_sh;
    fat_area   = 64'(b.fat_copies) * fat_len;
    first_data = 64'(b.reserved_count) + fat_area + root_secs;
    if (first_data >= total) return r;

    ncl = (total - first_data) >> clu_sh;
    if (width == 6'd0) width = (ncl <= 64'(fat12_limit_cfg)) ? FAT_W12 : FAT_W16;

    r.valid_res       = 1'b1;
    r.fat_width       = width;
    r.volume_sectors  = total[31:0];
    r.sectors_per_fat = fat_len[31:0];
    r.data_start      = first_data[31:0];
    r.clusters        = ncl[31:0];
    if (width == FAT_W32) begin
      r.root_cluster_out = b.root_start_cluster;
    end else begin
      r.root_sector      = 32'(64'(b.reserved_count) + fat_area);
      r.root_entries_out = b.root_entry_count;
    end
    return r;
  endfunction

  // First data sector of a block whose sector size is already a power of two.
  function automatic logic [63:0] first_data_of(input bpb_t b);
    int unsigned sh;
    logic [63:0] fat_len;
    sh = 9;
    for (int s = 9; s <= 12; s++) if (b.sector_bytes[s]) sh = s;
    fat_len = (b.fat_size_small != 16'd0) ? 64'(b.fat_size_small) : 64'(b.fat_size_large);
    return 64'(b.reserved_count) + 64'(b.fat_copies) * fat_len +
           ((64'(b.root_entry_count) * 64'd32 + 64'(b.sector_bytes) - 64'd1) >> sh);
  endfunction

  // A block that passes the field checks, with sizes aimed at the device limit,
  // the data area and the FAT12 cluster limit often enough to hit their edges.
  function automatic bpb_t wellformed_block();
    bpb_t        b;
    int unsigned sec_sh;
    int unsigned clu_sh;
    logic [63:0] total, cap, budget, fat_len;
    bit          fat32;
    sec_sh = $urandom_range(12, 9);
    clu_sh = $urandom_range(7, 0);
    b.sector_bytes    = 16'(1 << sec_sh);
    b.cluster_sectors = 8'(1 << clu_sh);
    b.reserved_count = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                                : 16'($urandom_range(64, 1));
    b.fat_copies = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 1))
                                            : 8'($urandom_range(2, 1));
    case ($urandom_range(3))
      0:       b.root_entry_count = 16'd0;
      1:       b.root_entry_count = 16'd512;
      2:       b.root_entry_count = 16'($urandom_range(1024));
      default: b.root_entry_count = 16'($urandom);
    endcase
    b.root_start_cluster = $urandom;
    b.total_small    = 16'd0;
    b.total_large    = $urandom;
    b.fat_size_small = 16'd0;
    b.fat_size_large = $urandom;

    case ($urandom_range(3))
      0: total = 64'($urandom_range(65535, 1));
      1: total = 64'($urandom_range(4000000, 1));
      2: total = 64'($urandom_range(32'hFFFF_FFFF, 1));
      default: begin
        // Right at the device or volume size limit.
        cap = (dev_sectors_cfg > 64'(VOLUME_SECTOR_MAX)) ? 64'(VOLUME_SECTOR_MAX)
                                                           : dev_sectors_cfg;
        total = ((cap >> (sec_sh - 9)) + 64'($urandom_range(2)) - 64'd1) & 64'hFFFF_FFFF;
      end
    endcase

    fat32  = $urandom_range(1);
    budget = total / (64'(b.fat_copies) * 64'd2);
    if (budget == 64'd0) budget = 64'd1;
    fat_len = 64'($urandom_range(budget[31:0], 1));
    if (fat32) begin
      b.fat_size_large = fat_len[31:0];
    end else begin
      if (fat_len > 64'd65535) fat_len = 64'($urandom_range(65535, 1));
      b.fat_size_small = fat_len[15:0];
      // Cluster count placed around the FAT12 limit.
      if ($urandom_range(3) == 0) begin
        total = (first_data_of(b) +
                 ((64'(fat12_limit_cfg) + 64'($urandom_range(2)) - 64'd1) << clu_sh) +
                 64'($urandom_range((1 << clu_sh) - 1))) & 64'hFFFF_FFFF;
      end
    end

    if (total <= 64'd65535 && total != 64'd0 && $urandom_range(1)) begin
      b.total_small = total[15:0];
    end else begin
      b.total_large = total[31:0];
    end
    return b;
  endfunction

  // A well-formed block with one field broken.
  function automatic bpb_t broken_block();
    bpb_t        b;
    logic [63:0] first_data;
    b = wellformed_block();
    case ($urandom_range(6))
      0: b.sector_bytes = $urandom_range(1) ? 16'd256 : 16'($urandom);
      1: b.cluster_sectors = $urandom_range(1) ? 8'd0 : 8'($urandom);
      2: b.reserved_count = 16'd0;
      3: b.fat_copies = 8'd0;
      4: begin
        b.fat_size_small = 16'd0;
        b.fat_size_large = 32'd0;
      end
      5: begin
        b.total_small = 16'd0;
        b.total_large = 32'd0;
      end
      default: begin
        // Data area reaching the end of the volume or beyond.
        first_data    = first_data_of(b);
        b.total_small = 16'd0;
        b.total_large = first_data[31:0] - 32'($urandom_range(1));
      end
    endcase
    return b;
  endfunction

  function automatic bpb_t random_block();
    int unsigned pick;
    bpb_t        b;
    pick = $urandom_range(99);
    if (pick < 70) begin
      b = wellformed_block();
    end else if (pick < 85) begin
      b = broken_block();
    end else begin
      b = bpb_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
    return b;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Wait until no request is queued, driven or in flight.
  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_valid_i || expected_layouts.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back cycles while the unit is idle.
  task automatic set_config(input logic [63:0] dev, input logic [63:0] limit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DEVICE_SECTORS;
    cfg_data_i  <= dev;
    @(posedge clk_i);
    dev_sectors_cfg = dev;
    cfg_index_i <= CFG_FAT12_LIMIT;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    fat12_limit_cfg = limit[27:0];
    cfg_we_i <= 1'b0;
  endtask

  // Request driver: holds a request until it is taken, then maybe idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_q      <= '0;
    end else begin
      if (in_valid_i && in_ready_o) expected_layouts.push_back(predict_layout(req_q));
      if (!in_valid_i || in_ready_o) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_q      <= pending_blocks.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and in-order comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (expected_layouts.size() == 0) begin
          $error("layout result with no request outstanding");
          mismatch_count++;
        end else begin
          expected_layout = expected_layouts.pop_front();
          check_field("valid_res", expected_layout.valid_res, result.valid_res);
          check_field("fat_width", expected_layout.fat_width, result.fat_width);
          check_field("volume_sectors", expected_layout.volume_sectors,
                      result.volume_sectors);
          check_field("sectors_per_fat", expected_layout.sectors_per_fat,
                      result.sectors_per_fat);
          check_field("data_start", expected_layout.data_start, result.data_start);
          check_field("clusters", expected_layout.clusters, result.clusters);
          check_field("root_cluster_out", expected_layout.root_cluster_out,
                      result.root_cluster_out);
          check_field("root_sector", expected_layout.root_sector, result.root_sector);
          check_field("root_entries_out", expected_layout.root_entries_out,
                      result.root_entries_out);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fat_boot_sector_layout_unit regression: fail");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned chunks;
    logic [63:0] dev;
    logic [63:0] limit;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A device size of zero after reset rejects even good blocks.
    send_idle_pct = 19;
    recv_idle_pct = 62;
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 8, 32, 2, 0, 4000000, 0, 3900, 0, 2});
    wait_drained();

    // Directed blocks on an unbounded device.
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'd4084);
    // Floppy-sized FAT12, FAT16 from the large total, plain FAT32.
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 4, 1, 2, 0, 200000, 200, 0, 512, 0});
    pending_blocks.push_back(bpb_t'{512, 8, 32, 2, 0, 4000000, 0, 3900, 0, 2});
    // FAT32 whose root entry count still adds sectors before the data area.
    pending_blocks.push_back(bpb_t'{4096, 1, 32, 2, 0, 1000000, 0, 1000, 512, 5});
    // Both FAT sizes set: the small one wins, and the large total is ignored.
    pending_blocks.push_back(bpb_t'{2048, 2, 4, 2, 60000, 32'hFFFF_FFFF, 100, 500, 512,
                                    32'hFFFF_FFFF});
    // Both FAT sizes zero.
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 60000, 0, 0, 0, 512, 0});
    // Sector sizes below the device sector, zero and all ones.
    pending_blocks.push_back(bpb_t'{256, 1, 1, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{0, 1, 1, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                                    32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                    32'hFFFF_FFFF});
    // Volume of exactly 2^32 device sectors, then one logical sector more.
    pending_blocks.push_back(bpb_t'{1024, 1, 1, 1, 0, 32'h8000_0000, 0, 1000, 0, 7});
    pending_blocks.push_back(bpb_t'{1024, 1, 1, 1, 0, 32'h8000_0001, 0, 1000, 0, 7});
    // Largest total with the largest cluster.
    pending_blocks.push_back(bpb_t'{512, 128, 1, 1, 0, 32'hFFFF_FFFF, 0, 32'hFF_FFFF, 0,
                                    32'hFFFF_FFFF});
    // Cluster sizes of zero, not a power of two, and all ones.
    pending_blocks.push_back(bpb_t'{512, 0, 1, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 3, 1, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 255, 1, 2, 2880, 0, 9, 0, 224, 0});
    // No reserved sectors, no FAT copies, the most FAT copies.
    pending_blocks.push_back(bpb_t'{512, 1, 0, 2, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 1, 1, 0, 2880, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 1, 1, 255, 60000, 0, 200, 0, 0, 0});
    // Both totals zero.
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 0, 0, 9, 0, 224, 0});
    // Data area starting at the last sector of the volume, then one sector earlier.
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 34, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 35, 0, 9, 0, 224, 0});
    // Cluster count one past the FAT12 limit and two past it.
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 4118, 0, 9, 0, 224, 0});
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 4119, 0, 9, 0, 224, 0});
    // Largest root directory.
    pending_blocks.push_back(bpb_t'{512, 1, 1, 2, 60000, 0, 9, 0, 16'hFFFF, 0});
    wait_drained();

    // Random phases, each under its own register setting. Every chunk drains
    // completely before the next one is queued.
    for (int p = 0; p < 6; p++) begin
      chunks = 4;
      case (p)
        0: begin
          dev   = 64'hFFFF_FFFF_FFFF_FFFF;
          limit = 64'd4084;
        end
        1: begin
          dev   = {$urandom, $urandom};
          limit = 64'd0;
        end
        2: begin
          dev   = 64'h1_0000_0000;
          limit = 64'h0FFF_FFFF;
        end
        3: begin
          dev   = 64'($urandom_range(200000, 1));
          limit = 64'($urandom_range(70000));
        end
        4: begin
          dev   = 64'hFFFF_FFFF;
          limit = {$urandom, $urandom};
        end
        default: begin
          // An empty device rejects every block; one chunk is enough.
          dev    = 64'd0;
          limit  = 64'd4084;
          chunks = 1;
        end
      endcase
      if (p < 2) begin
        send_idle_pct = 19;
        recv_idle_pct = 62;
      end else if (p < 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(dev, limit);
      for (int c = 0; c < chunks; c++) begin
        for (int n = 0; n < CHUNK_ITEMS; n++) pending_blocks.push_back(random_block());
        wait_drained();
      end
    end

    if (mismatch_count == 0 && expected_layouts.size() == 0) begin
      $display("fat_boot_sector_layout_unit regression: pass");
    end else begin
      $display("fat_boot_sector_layout_unit regression: fail");
    end
    $finish;
  end

endmodule

### fat_boot_sector_layout_unit.f
rtl/core/fbsl_pkg.sv
rtl/core/fbsl_bpb_reg.sv
rtl/core/fbsl_layout.sv
rtl/core/fat_boot_sector_layout_unit.sv
rtl/core/fbsl_checker.sv
sim/fat_boot_sector_layout_unit_test.sv
